@@ rtl/shw_pkg.sv @@
// Package: types, constants and codes of the subsystem heartbeat watchdog.
package shw_pkg;
    localparam int ENTRIES    = 16;
    localparam int IDX_BITS   = 4;
    localparam int TIMER_BITS = 24;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_SETIVL = 3'd2;
    localparam logic [2:0] CMD_SETTYP = 3'd3;
    localparam logic [2:0] CMD_REPORT = 3'd4;
    localparam logic [2:0] CMD_TICK   = 3'd5;
    localparam logic [2:0] CMD_INFRA  = 3'd6;
    localparam logic [2:0] CMD_QUERY  = 3'd7;

    localparam logic [2:0] ST_KEEP     = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_INIT     = 3'd2;
    localparam logic [2:0] ST_FINAL    = 3'd4;
    localparam logic [2:0] ST_SHUTDOWN = 3'd5;
    localparam logic [1:0] HL_KEEP     = 2'd0;
    localparam logic [1:0] HL_OK       = 2'd1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_EXISTS  = 2'd2;

    localparam logic [1:0] CFG_MULT   = 2'd0;
    localparam logic [1:0] CFG_ADD    = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_TREAD, S_TCALC, S_TCHECK, S_TFIN, S_OREAD
    } t_state;

    // Entry word kept in memory
    typedef struct packed {
        logic [2:0]            state;
        logic [1:0]            health;
        logic [1:0]            kind;
        logic [15:0]           message;
        logic [23:0]           interval;
        logic [TIMER_BITS-1:0] elapsed;
        logic                  stalled;
    } t_entry;
endpackage

@@ rtl/subsystem_heartbeat_watchdog.sv @@
// Top level of the subsystem heartbeat watchdog.
//
// Commands enter on start when busy is low; each gives one result word on the
// o_ entry ports, marked by o_done for one cycle. The receiver cannot stall.
// The table lives in one 16-entry synchronous memory with a registered read.
// A non-tick command walks read, execute (write back), read back and done:
// o_done rises and busy drops in the same cycle, so a new command can be
// taken in the cycle in which o_done is high.
// A tick walks all 16 entries with read, compare and write per entry, decides
// the publish, then does read, execute and read back of the addressed entry.
// The multiply of interval by the tolerance factor is registered before the
// compare. Reset clears valid flags, infrastructure state goes to idle and the
// publish counter to zero; entry data is undefined until an add writes it.
// Configuration writes come through i_cfg_we, i_cfg_index, i_cfg_data.
module subsystem_heartbeat_watchdog (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic [2:0]  i_command,
    input  logic [3:0]  i_subsystem_index,
    input  logic [2:0]  i_new_state,
    input  logic [1:0]  i_new_health,
    input  logic [15:0] i_message_id,
    input  logic [23:0] i_interval_ticks,
    input  logic [1:0]  i_subsystem_kind,
    output logic        o_done,
    output logic        o_publish,
    output logic [1:0]  o_error_code,
    output logic        o_entry_valid,
    output logic [2:0]  o_entry_state,
    output logic [1:0]  o_entry_health,
    output logic [1:0]  o_entry_kind,
    output logic [15:0] o_entry_message,
    output logic        o_entry_stalled,
    output logic [23:0] o_entry_elapsed,
    output logic [23:0] o_entry_interval,
    output logic [2:0]  o_infrastructure_state
);
    import shw_pkg::*;

    t_entry mem [ENTRIES];
    t_entry r_rd;
    logic [IDX_BITS-1:0] rd_addr;

    t_state r_st, n_st;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [2:0]  r_infra, n_infra;
    logic [TIMER_BITS-1:0] r_pcnt, n_pcnt;
    logic [7:0]  r_mult;
    logic [15:0] r_add;
    logic [23:0] r_period;
    logic [2:0]  r_cmd;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic [IDX_BITS-1:0] r_sub;
    logic [2:0]  r_nst;
    logic [1:0]  r_nhl, r_kind;
    logic [15:0] r_msg;
    logic [23:0] r_ivl;
    logic r_pub, n_pub, r_any, n_any, r_fresh, n_fresh;
    logic [1:0] r_err, n_err;
    logic [31:0] r_prod;
    t_entry r_cur, n_cur;
    logic   n_we;
    t_entry n_wd;
    logic   r_done, n_done;

    // write back at the edge that ends execute or check, so the next read sees it
    always_ff @(posedge i_clk) begin
        if (n_we) mem[r_idx] <= n_wd;
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        rd_addr = r_idx;
        if (r_st == S_IDLE) rd_addr = i_subsystem_index;
    end

    always_comb begin
        unique case (r_st)
            S_IDLE:   n_st = start ? ((i_command == CMD_TICK) ? S_TREAD : S_READ) : S_IDLE;
            S_READ:   n_st = S_EXEC;
            S_EXEC:   n_st = S_OREAD;
            S_TREAD:  n_st = S_TCALC;
            S_TCALC:  n_st = S_TCHECK;
            S_TCHECK: n_st = (r_idx == IDX_BITS'(ENTRIES - 1)) ? S_TFIN : S_TREAD;
            S_TFIN:   n_st = S_READ;
            S_OREAD:  n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    always_comb begin
        logic [2:0] s;
        logic [1:0] h;
        logic ex, clr;
        logic [TIMER_BITS+3:0] lhs;
        logic [32:0] rhs;
        n_valid = r_valid; n_infra = r_infra; n_pcnt = r_pcnt;
        n_idx = r_idx; n_pub = r_pub; n_any = r_any; n_fresh = r_fresh;
        n_err = r_err; n_cur = r_cur; n_we = 1'b0; n_wd = r_rd; n_done = 1'b0;
        ex = r_valid[r_idx];
        s = '0; h = '0; clr = 1'b0; lhs = '0; rhs = '0;
        unique case (r_st)
            S_IDLE: begin
                n_idx = i_subsystem_index;
                n_pub = 1'b0; n_err = ERR_NONE; n_any = 1'b0; n_fresh = 1'b0;
                if (start && i_command == CMD_TICK) begin
                    n_idx = '0;
                    n_pcnt = (r_pcnt == TIMER_MAX) ? r_pcnt : r_pcnt + 1'b1;
                end
            end
            S_TREAD: ;
            S_TCALC: begin
                n_cur = r_rd;
                n_cur.elapsed = (r_rd.elapsed == TIMER_MAX) ? r_rd.elapsed
                                                           : r_rd.elapsed + 1'b1;
            end
            S_TCHECK: begin
                lhs = {r_cur.elapsed, 4'b0};
                rhs = {1'b0, r_prod} + {13'b0, r_add, 4'b0};
                n_wd = r_cur;
                if (r_valid[r_idx]) begin
                    n_any = 1'b1;
                    n_we = 1'b1;
                    if (r_cur.interval != '0 && r_cur.state != ST_IDLE &&
                        r_cur.state != ST_SHUTDOWN && !r_cur.stalled &&
                        {5'b0, lhs} > rhs) begin
                        n_wd.stalled = 1'b1;
                        n_fresh = 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
            end
            S_TFIN: begin
                n_pub = r_any && (r_fresh || r_pcnt >= TIMER_BITS'(r_period));
                if (n_pub) n_pcnt = '0;
                // return to the addressed entry for the result word
                n_idx = r_sub;
            end
            S_READ: ;
            S_EXEC: begin
                n_wd = r_rd;
                case (r_cmd)
                    CMD_ADD: if (ex) n_err = ERR_EXISTS;
                        else begin
                            n_valid[r_idx] = 1'b1; n_we = 1'b1; n_pub = 1'b1;
                            n_wd.state = ST_IDLE; n_wd.health = HL_OK;
                            n_wd.kind = r_kind; n_wd.message = '0;
                            n_wd.interval = r_ivl; n_wd.elapsed = '0;
                            n_wd.stalled = 1'b0;
                        end
                    CMD_REMOVE: if (!ex) n_err = ERR_UNKNOWN;
                        else begin n_valid[r_idx] = 1'b0; n_pub = 1'b1; end
                    CMD_SETIVL: if (!ex) n_err = ERR_UNKNOWN;
                        else begin
                            n_we = 1'b1; n_wd.interval = r_ivl; n_wd.elapsed = '0;
                        end
                    CMD_SETTYP: if (!ex) n_err = ERR_UNKNOWN;
                        else begin n_we = 1'b1; n_wd.kind = r_kind; end
                    CMD_REPORT: if (!ex) n_err = ERR_UNKNOWN;
                        else begin
                            n_we = 1'b1; n_wd.elapsed = '0;
                            clr = r_rd.stalled;
                            n_wd.stalled = 1'b0;
                            if (r_nst != ST_KEEP || r_nhl != HL_KEEP || clr) begin
                                s = (r_nst != ST_KEEP) ? r_nst : r_rd.state;
                                h = (r_nhl != HL_KEEP) ? r_nhl : r_rd.health;
                                n_pub = clr || s != r_rd.state || h != r_rd.health ||
                                        r_msg != r_rd.message;
                                n_wd.state = s; n_wd.health = h;
                                n_wd.message = r_msg;
                            end
                        end
                    CMD_INFRA:
                        if (r_nst >= ST_INIT && r_nst <= ST_FINAL && r_infra != r_nst) begin
                            n_infra = r_nst; n_pub = 1'b1;
                        end
                    CMD_QUERY: if (!ex) n_err = ERR_UNKNOWN;
                    default: ;
                endcase
                if (n_pub) n_pcnt = '0;
            end
            S_OREAD: n_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_valid <= '0; r_infra <= ST_IDLE; r_pcnt <= '0;
            r_mult <= 8'd24; r_add <= 16'd100; r_period <= 24'd30000;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st; r_valid <= n_valid; r_infra <= n_infra; r_pcnt <= n_pcnt;
            r_done <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MULT:   r_mult <= i_cfg_data[7:0];
                    CFG_ADD:    r_add <= i_cfg_data[15:0];
                    CFG_PERIOD: r_period <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && start) begin
            r_cmd <= i_command;
            r_sub <= i_subsystem_index;
            r_nst <= (i_new_state > ST_SHUTDOWN) ? ST_KEEP : i_new_state;
            r_nhl <= i_new_health; r_msg <= i_message_id;
            r_ivl <= i_interval_ticks; r_kind <= i_subsystem_kind;
        end
        r_idx <= n_idx; r_pub <= n_pub; r_any <= n_any; r_fresh <= n_fresh;
        r_err <= n_err; r_cur <= n_cur;
        r_prod <= r_rd.interval * r_mult;
    end

    // Final S_READ after the tick walk leaves S_EXEC doing nothing for tick.
    assign busy = (r_st != S_IDLE);
    assign o_done = r_done;
    assign o_publish = r_pub;
    assign o_error_code = r_err;
    assign o_entry_valid = r_valid[r_idx];
    assign o_entry_state    = r_valid[r_idx] ? r_rd.state : '0;
    assign o_entry_health   = r_valid[r_idx] ? r_rd.health : '0;
    assign o_entry_kind     = r_valid[r_idx] ? r_rd.kind : '0;
    assign o_entry_message  = r_valid[r_idx] ? r_rd.message : '0;
    assign o_entry_stalled  = r_valid[r_idx] ? r_rd.stalled : 1'b0;
    assign o_entry_elapsed  = r_valid[r_idx] ? r_rd.elapsed[23:0] : '0;
    assign o_entry_interval = r_valid[r_idx] ? r_rd.interval : '0;
    assign o_infrastructure_state = r_infra;
endmodule

@@ rtl/shw_checker.sv @@
// Port checker for the heartbeat watchdog, bound to the top level.
module shw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_error_code,
    input logic       o_publish,
    input logic [2:0] o_infrastructure_state
);
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy)) else $error("done without a command in flight");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_error_code != 2'd3) else $error("bad error code");
    a_infra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> $stable(o_infrastructure_state) || $past(start))
        else $error("infra state moved while idle");
    a_pub_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !o_done) |-> !o_publish) else $error("publish while idle");
endmodule

bind subsystem_heartbeat_watchdog shw_checker u_chk (.*);

@@ tb/sv/subsystem_heartbeat_watchdog_tb.sv @@
// Testbench for the subsystem heartbeat watchdog: directed table plus random commands.
`timescale 1ns / 100ps
module subsystem_heartbeat_watchdog_tb;
    import shw_pkg::*;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  index;
        logic [2:0]  new_state;
        logic [1:0]  new_health;
        logic [15:0] message;
        logic [23:0] interval;
        logic [1:0]  kind;
    } t_cmd;

    typedef struct packed {
        logic        publish;
        logic [1:0]  error_code;
        logic        valid;
        logic [2:0]  state;
        logic [1:0]  health;
        logic [1:0]  kind;
        logic [15:0] message;
        logic        stalled;
        logic [23:0] elapsed;
        logic [23:0] interval;
        logic [2:0]  infra;
    } t_status;

    typedef struct {
        t_cmd    cmd;
        logic    fixed;
        t_status status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MULT;
    logic [23:0] i_cfg_data = '0;
    t_cmd        cmd_drv = '0;
    logic        o_done;
    t_status     status_out;

    subsystem_heartbeat_watchdog dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_command(cmd_drv.command), .i_subsystem_index(cmd_drv.index),
        .i_new_state(cmd_drv.new_state), .i_new_health(cmd_drv.new_health),
        .i_message_id(cmd_drv.message), .i_interval_ticks(cmd_drv.interval),
        .i_subsystem_kind(cmd_drv.kind), .o_done(o_done),
        .o_publish(status_out.publish), .o_error_code(status_out.error_code),
        .o_entry_valid(status_out.valid), .o_entry_state(status_out.state),
        .o_entry_health(status_out.health), .o_entry_kind(status_out.kind),
        .o_entry_message(status_out.message), .o_entry_stalled(status_out.stalled),
        .o_entry_elapsed(status_out.elapsed), .o_entry_interval(status_out.interval),
        .o_infrastructure_state(status_out.infra)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic        m_valid [ENTRIES];
    logic [2:0]  m_state [ENTRIES];
    logic [1:0]  m_health [ENTRIES];
    logic [1:0]  m_kind [ENTRIES];
    logic [15:0] m_msg [ENTRIES];
    logic [23:0] m_ivl [ENTRIES];
    logic [23:0] m_elapsed [ENTRIES];
    logic        m_stall [ENTRIES];
    logic [2:0]  m_infra;
    logic [23:0] m_pubcnt;
    logic [7:0]  tol_mult;
    logic [15:0] tol_add;
    logic [23:0] pub_period;

    t_status expected_words[$];
    int      errors = 0;
    longint  cycles = 0;

    function automatic t_status watchdog_step(t_cmd c);
        t_status r;
        logic [2:0] ns, s;
        logic [1:0] h;
        logic pub, any, fresh, ex;
        logic [1:0] err;
        logic [63:0] lhs, rhs;
        r = '0;
        pub = 1'b0;
        err = ERR_NONE;
        ns = (c.new_state > 3'd5) ? ST_KEEP : c.new_state;
        ex = m_valid[c.index];
        case (c.command)
            CMD_ADD: begin
                if (ex) err = ERR_EXISTS;
                else begin
                    m_valid[c.index] = 1'b1; m_state[c.index] = ST_IDLE;
                    m_health[c.index] = HL_OK; m_kind[c.index] = c.kind;
                    m_msg[c.index] = '0; m_ivl[c.index] = c.interval;
                    m_elapsed[c.index] = '0; m_stall[c.index] = 1'b0; pub = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!ex) err = ERR_UNKNOWN;
                else begin
                    m_valid[c.index] = 1'b0; pub = 1'b1;
                end
            end
            CMD_SETIVL: begin
                if (!ex) err = ERR_UNKNOWN;
                else begin
                    m_ivl[c.index] = c.interval; m_elapsed[c.index] = '0;
                end
            end
            CMD_SETTYP: begin
                if (!ex) err = ERR_UNKNOWN;
                else m_kind[c.index] = c.kind;
            end
            CMD_REPORT: begin
                if (!ex) err = ERR_UNKNOWN;
                else begin
                    m_elapsed[c.index] = '0;
                    if (m_stall[c.index]) begin
                        m_stall[c.index] = 1'b0; pub = 1'b1;
                    end
                    if (ns != ST_KEEP || c.new_health != HL_KEEP || pub) begin
                        s = (ns != ST_KEEP) ? ns : m_state[c.index];
                        h = (c.new_health != HL_KEEP) ? c.new_health : m_health[c.index];
                        if (s != m_state[c.index] || h != m_health[c.index] ||
                            c.message != m_msg[c.index]) pub = 1'b1;
                        m_state[c.index] = s; m_health[c.index] = h;
                        m_msg[c.index] = c.message;
                    end
                end
            end
            CMD_TICK: begin
                any = 1'b0; fresh = 1'b0;
                if (m_pubcnt != TIMER_MAX) m_pubcnt++;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (m_valid[i]) begin
                        any = 1'b1;
                        if (m_elapsed[i] != TIMER_MAX) m_elapsed[i]++;
                        lhs = 64'(m_elapsed[i]) << 4;
                        rhs = 64'(m_ivl[i]) * 64'(tol_mult) + (64'(tol_add) << 4);
                        if (m_ivl[i] != '0 && m_state[i] != ST_IDLE &&
                            m_state[i] != ST_SHUTDOWN && !m_stall[i] && lhs > rhs) begin
                            m_stall[i] = 1'b1; fresh = 1'b1;
                        end
                    end
                end
                if (any && (fresh || m_pubcnt >= pub_period)) pub = 1'b1;
            end
            CMD_INFRA: begin
                if (ns >= ST_INIT && ns <= ST_FINAL && m_infra != ns) begin
                    m_infra = ns; pub = 1'b1;
                end
            end
            default: if (!ex) err = ERR_UNKNOWN;
        endcase
        if (pub) m_pubcnt = '0;
        r.publish = pub;
        r.error_code = err;
        if (m_valid[c.index]) begin
            r.valid = 1'b1; r.state = m_state[c.index]; r.health = m_health[c.index];
            r.kind = m_kind[c.index]; r.message = m_msg[c.index];
            r.stalled = m_stall[c.index]; r.elapsed = m_elapsed[c.index];
            r.interval = m_ivl[c.index];
        end
        r.infra = m_infra;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_status exp_w;
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("subsystem_heartbeat_watchdog test failed");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, actual %p", $time, status_out);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (status_out !== exp_w) begin
                    $display("%0t: mismatch, expected %p actual %p", $time, exp_w, status_out);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MULT: tol_mult = val[7:0];
            CFG_ADD:  tol_add = val[15:0];
            default:  pub_period = val;
        endcase
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
            ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) @(negedge i_clk);
    endtask

    // drive one word at a falling edge; hold until accepted
    task automatic send_cmd(t_cmd c, logic fixed, t_status want, logic gaps);
        t_status p;
        if (gaps) random_gap();
        cmd_drv = c;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = watchdog_step(c);
        if (fixed && p !== want) begin
            $display("%0t: table row disagrees, expected %p predicted %p", $time, want, p);
            errors++;
        end
        expected_words = {expected_words, p};
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_words.size() != 0 && guard < 100000) begin
            @(negedge i_clk); guard++;
        end
        repeat (80) @(negedge i_clk);
    endtask

    function automatic t_cmd rand_cmd(int mode);
        t_cmd c;
        int r;
        c.index = 4'($urandom_range(0, 15));
        c.new_state = 3'($urandom_range(0, 7));
        c.new_health = 2'($urandom_range(0, 3));
        c.message = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        c.interval = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20));
        c.kind = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (mode == 0) c.command = 3'($urandom_range(0, 7));
        else if (r < 45) c.command = CMD_TICK;
        else if (r < 70) c.command = CMD_REPORT;
        else if (r < 78) c.command = CMD_ADD;
        else if (r < 82) c.command = CMD_REMOVE;
        else if (r < 87) c.command = CMD_SETIVL;
        else if (r < 90) c.command = CMD_SETTYP;
        else if (r < 94) c.command = CMD_INFRA;
        else c.command = CMD_QUERY;
        return c;
    endfunction

    t_row dir_table[$];

    function automatic t_cmd mk(logic [2:0] op, logic [3:0] ix, logic [2:0] s,
                                logic [1:0] h, logic [15:0] m, logic [23:0] iv,
                                logic [1:0] k);
        t_cmd c;
        c.command = op; c.index = ix; c.new_state = s; c.new_health = h;
        c.message = m; c.interval = iv; c.kind = k;
        return c;
    endfunction

    function automatic t_status idle_status(logic [1:0] err);
        t_status s;
        s = '0; s.error_code = err; s.infra = ST_IDLE;
        return s;
    endfunction

    task automatic add_row(t_cmd c, logic fixed, t_status s);
        t_row r;
        r.cmd = c; r.fixed = fixed; r.status = s;
        dir_table = {dir_table, r};
    endtask

    initial begin
        t_status s;
        for (int i = 0; i < ENTRIES; i++) begin
            m_valid[i] = 1'b0; m_state[i] = '0; m_health[i] = '0; m_kind[i] = '0;
            m_msg[i] = '0; m_ivl[i] = '0; m_elapsed[i] = '0; m_stall[i] = 1'b0;
        end
        m_infra = ST_IDLE; m_pubcnt = '0;
        tol_mult = 8'd24; tol_add = 16'd100; pub_period = 24'd30000;

        // errors right after reset
        add_row(mk(CMD_QUERY, 4'd15, '0, '0, '0, '0, '0), 1'b1, idle_status(ERR_UNKNOWN));
        add_row(mk(CMD_REMOVE, 4'd0, '0, '0, '0, '0, '0), 1'b1, idle_status(ERR_UNKNOWN));
        add_row(mk(CMD_REPORT, 4'd3, 3'd3, 2'd2, 16'hFFFF, '0, '0), 1'b1,
                idle_status(ERR_UNKNOWN));
        add_row(mk(CMD_SETIVL, 4'd3, '0, '0, '0, 24'hFFFFFF, '0), 1'b1,
                idle_status(ERR_UNKNOWN));
        add_row(mk(CMD_SETTYP, 4'd3, '0, '0, '0, '0, 2'd3), 1'b1, idle_status(ERR_UNKNOWN));
        add_row(mk(CMD_TICK, 4'd0, '0, '0, '0, '0, '0), 1'b1, idle_status(ERR_NONE));
        s = '0; s.publish = 1'b1; s.valid = 1'b1; s.state = ST_IDLE; s.health = HL_OK;
        s.kind = 2'd3; s.interval = 24'hFFFFFF; s.infra = ST_IDLE;
        add_row(mk(CMD_ADD, 4'd15, '0, '0, '0, 24'hFFFFFF, 2'd3), 1'b1, s);
        s.publish = 1'b0; s.error_code = ERR_EXISTS;
        add_row(mk(CMD_ADD, 4'd15, '0, '0, '0, '0, '0), 1'b1, s);
        add_row(mk(CMD_ADD, 4'd0, '0, '0, '0, 24'd1, 2'd0), 1'b0, s);
        add_row(mk(CMD_REPORT, 4'd0, 3'd3, 2'd3, 16'hFFFF, '0, '0), 1'b0, s);
        add_row(mk(CMD_REPORT, 4'd0, '0, '0, 16'h1234, '0, '0), 1'b0, s);  // heartbeat only
        add_row(mk(CMD_REPORT, 4'd0, 3'd7, '0, 16'hFFFF, '0, '0), 1'b0, s); // unused code
        for (int i = 0; i < 4; i++)
            add_row(mk(CMD_TICK, 4'd0, '0, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_TICK, 4'd0, '0, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_REPORT, 4'd0, '0, '0, 16'h0, '0, '0), 1'b0, s);  // clears stall
        add_row(mk(CMD_SETIVL, 4'd0, '0, '0, '0, 24'd0, '0), 1'b0, s);
        add_row(mk(CMD_SETTYP, 4'd0, '0, '0, '0, '0, 2'd2), 1'b0, s);
        add_row(mk(CMD_INFRA, 4'd0, 3'd3, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_INFRA, 4'd0, 3'd3, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_INFRA, 4'd0, 3'd5, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_INFRA, 4'd0, 3'd2, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_REMOVE, 4'd15, '0, '0, '0, '0, '0), 1'b0, s);
        add_row(mk(CMD_QUERY, 4'd0, '0, '0, '0, '0, '0), 1'b0, s);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero multiplier and a small additive so the stall rows fire quickly
        write_reg(CFG_MULT, 24'd0);
        write_reg(CFG_ADD, 24'd2);
        foreach (dir_table[i])
            send_cmd(dir_table[i].cmd, dir_table[i].fixed, dir_table[i].status, 1'b0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(CFG_MULT, 24'd255); write_reg(CFG_ADD, 24'd0);
                          write_reg(CFG_PERIOD, 24'd1); end
                1: begin write_reg(CFG_MULT, 24'd16); write_reg(CFG_ADD, 24'd3);
                          write_reg(CFG_PERIOD, 24'd5); end
                2: begin write_reg(CFG_MULT, 24'd24); write_reg(CFG_ADD, 24'hFFFF);
                          write_reg(CFG_PERIOD, 24'hFFFFFF); end
                3: begin write_reg(CFG_MULT, 24'($urandom_range(0, 255)));
                          write_reg(CFG_ADD, 24'($urandom_range(0, 8)));
                          write_reg(CFG_PERIOD, 24'($urandom_range(1, 40))); end
                default: begin write_reg(CFG_MULT, 24'd8); write_reg(CFG_ADD, 24'd1);
                          write_reg(CFG_PERIOD, 24'd0); end
            endcase
            for (int n = 0; n < 260; n++)
                send_cmd(rand_cmd(($urandom_range(0, 9) == 0) ? 0 : 1), 1'b0, '0, 1'b1);
            drain();
        end

        if (expected_words.size() != 0) begin
            $display("%0t: %0d words never arrived", $time, expected_words.size());
            errors++;
        end
        if (errors == 0) $display("subsystem_heartbeat_watchdog test passed");
        else $display("subsystem_heartbeat_watchdog test failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/shw_pkg.sv
rtl/subsystem_heartbeat_watchdog.sv
rtl/shw_checker.sv
tb/sv/subsystem_heartbeat_watchdog_tb.sv
